// File: src/lcd4w_pkg.sv
// Shared types and constants for the 4-bit character LCD writer.
`default_nettype none

package lcd4w_pkg;

  // Request kinds carried on the input side
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_BYTE   = 2'd1;
  localparam logic [1:0] MODE_NIBBLE = 2'd2;
  localparam logic [1:0] MODE_INIT   = 2'd3;

  // Job phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  // Power-up sequence runs steps 1 to INIT_LAST
  localparam logic [3:0] INIT_FIRST = 4'd1;
  localparam logic [3:0] INIT_LAST  = 4'd9;

  localparam logic [7:0] WAIT_TICKS_RESET = 8'd255;

  typedef struct packed {
    logic [7:0] value;
    logic       is_byte;
    logic       sel;
  } seq_entry_t;

  typedef struct packed {
    logic       accepted;
    logic       busy;
    logic [3:0] nibble;
    logic       enable;
    logic       read_write;
    logic       sel;
  } result_t;

  // Power-up sequence contents
  function automatic seq_entry_t seq_lookup(input logic [3:0] step);
    seq_entry_t e;
    e = '{value: 8'h00, is_byte: 1'b0, sel: 1'b0};
    case (step)
      4'd1, 4'd2, 4'd3: e = '{value: 8'h03, is_byte: 1'b0, sel: 1'b0};
      4'd4:             e = '{value: 8'h02, is_byte: 1'b0, sel: 1'b0};
      4'd5:             e = '{value: 8'h28, is_byte: 1'b1, sel: 1'b0};
      4'd6:             e = '{value: 8'h0F, is_byte: 1'b1, sel: 1'b0};
      4'd7:             e = '{value: 8'h01, is_byte: 1'b1, sel: 1'b0};
      4'd8:             e = '{value: 8'h06, is_byte: 1'b1, sel: 1'b0};
      4'd9:             e = '{value: 8'h57, is_byte: 1'b1, sel: 1'b1};
      default:          e = '{value: 8'h00, is_byte: 1'b0, sel: 1'b0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: src/char_lcd_four_bit_writer.sv
// Top level of the 4-bit character LCD writer with stream ports.
// Each input word is one timer tick and gives exactly one output word with the
// pin levels after that tick. One word is taken every clock cycle while the
// output side keeps up. A word passes through the input register, then the
// tick update into the output register, where its result is held until taken.
// The rate is set by the single tick update of the job state. wait_ticks sets
// the length of each enable-high, enable-low and power-up wait phase in ticks
// and is read when a phase starts.
`default_nettype none

module char_lcd_four_bit_writer #(
  parameter int WAIT_COUNTER_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wait_ticks_we,
  input  wire logic [7:0]  wait_ticks_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // byte_value
  input  wire logic [2:0]  s_tuser,   // mode[1:0], is_data
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // reg_select, read_write, enable_pin,
                                      // bus_nibble[3:0], busy_res, accepted, zeros
);

  logic [7:0]         wait_ticks;
  logic               in_valid;
  logic [1:0]         in_mode;
  logic               in_is_data;
  logic [7:0]         in_byte;
  logic               advance;
  lcd4w_pkg::result_t res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= lcd4w_pkg::WAIT_TICKS_RESET;
    end else if (wait_ticks_we) begin
      wait_ticks <= wait_ticks_wdata;
    end
  end

  // Move a word on when the output register is free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode    <= s_tuser[1:0];
      in_is_data <= s_tuser[2];
      in_byte    <= s_tdata;
    end
  end

  lcd4w_core #(
    .WAIT_COUNTER_BITS(WAIT_COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .mode      (in_mode),
    .is_data   (in_is_data),
    .byte_value(in_byte),
    .wait_ticks(wait_ticks),
    .result    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'd0, res.accepted, res.busy, res.nibble, res.enable,
                  res.read_write, res.sel};
    end
  end

endmodule

`default_nettype wire

// File: src/lcd4w_core.sv
// Job state and per-tick update of the LCD strobe sequencer.
`default_nettype none

module lcd4w_core #(
  parameter int WAIT_COUNTER_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step_en,
  input  wire logic [1:0]            mode,
  input  wire logic                  is_data,
  input  wire logic [7:0]            byte_value,
  input  wire logic [7:0]            wait_ticks,
  output lcd4w_pkg::result_t         result
);

  localparam int LW = (WAIT_COUNTER_BITS > 8) ? WAIT_COUNTER_BITS : 8;
  localparam logic [LW-1:0] LIMIT = LW'((64'd1 << WAIT_COUNTER_BITS) - 64'd1);

  logic [1:0]                   phase, phase_next;
  logic [WAIT_COUNTER_BITS-1:0] wait_count, wait_count_next;
  logic [7:0]                   held_byte, held_byte_next;
  logic                         held_select, held_select_next;
  logic                         low_pend, low_pend_next;
  logic [3:0]                   init_step, init_step_next;
  logic [5:0]                   pins, pins_next;

  logic [LW-1:0]                wt_ext;
  logic [WAIT_COUNTER_BITS-1:0] load_val;
  logic                         acc;
  lcd4w_pkg::seq_entry_t        seq_e;
  logic [3:0]                   seq_step;

  // Phase length: clip to the counter, treat zero as one
  always_comb begin
    wt_ext = LW'(wait_ticks);
    if (wt_ext > LIMIT) begin
      wt_ext = LIMIT;
    end
    if (wt_ext == '0) begin
      wt_ext = LW'(1);
    end
    load_val = wt_ext[WAIT_COUNTER_BITS-1:0];
  end

  // Sequence step that would start at the end of this phase
  always_comb begin
    if (phase == lcd4w_pkg::PH_WAIT) begin
      seq_step = lcd4w_pkg::INIT_FIRST;
    end else begin
      seq_step = init_step + 4'd1;
    end
    seq_e = lcd4w_pkg::seq_lookup(seq_step);
  end

  // Advance the job by one tick
  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    held_byte_next   = held_byte;
    held_select_next = held_select;
    low_pend_next    = low_pend;
    init_step_next   = init_step;
    pins_next        = pins;
    acc              = 1'b0;
    if (phase == lcd4w_pkg::PH_IDLE) begin
      if (mode != lcd4w_pkg::MODE_TICK) begin
        acc            = 1'b1;
        init_step_next = 4'd0;
        low_pend_next  = 1'b0;
        case (mode)
          lcd4w_pkg::MODE_BYTE: begin
            held_byte_next   = byte_value;
            held_select_next = is_data;
            low_pend_next    = 1'b1;
            pins_next        = {is_data, 1'b1, byte_value[7:4]};
            phase_next       = lcd4w_pkg::PH_HIGH;
            wait_count_next  = load_val;
          end
          lcd4w_pkg::MODE_NIBBLE: begin
            pins_next       = {is_data, 1'b1, byte_value[3:0]};
            phase_next      = lcd4w_pkg::PH_HIGH;
            wait_count_next = load_val;
          end
          default: begin
            pins_next[4]    = 1'b0;
            phase_next      = lcd4w_pkg::PH_WAIT;
            wait_count_next = load_val;
          end
        endcase
      end
    end else if (wait_count <= WAIT_COUNTER_BITS'(1)) begin
      wait_count_next = '0;
      if (phase == lcd4w_pkg::PH_HIGH) begin
        // drop enable, start the low half
        pins_next[4]    = 1'b0;
        phase_next      = lcd4w_pkg::PH_LOW;
        wait_count_next = load_val;
      end else if (low_pend) begin
        low_pend_next   = 1'b0;
        pins_next       = {held_select, 1'b1, held_byte[3:0]};
        phase_next      = lcd4w_pkg::PH_HIGH;
        wait_count_next = load_val;
      end else if (phase == lcd4w_pkg::PH_WAIT ||
                   (init_step >= lcd4w_pkg::INIT_FIRST &&
                    init_step < lcd4w_pkg::INIT_LAST)) begin
        // next item of the power-up sequence
        init_step_next  = seq_step;
        phase_next      = lcd4w_pkg::PH_HIGH;
        wait_count_next = load_val;
        if (seq_e.is_byte) begin
          held_byte_next   = seq_e.value;
          held_select_next = seq_e.sel;
          low_pend_next    = 1'b1;
          pins_next        = {seq_e.sel, 1'b1, seq_e.value[7:4]};
        end else begin
          pins_next        = {seq_e.sel, 1'b1, seq_e.value[3:0]};
        end
      end else begin
        init_step_next = 4'd0;
        phase_next     = lcd4w_pkg::PH_IDLE;
      end
    end else begin
      wait_count_next = wait_count - WAIT_COUNTER_BITS'(1);
    end
  end

  // Hold job state, update on each processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lcd4w_pkg::PH_IDLE;
      wait_count  <= '0;
      held_byte   <= '0;
      held_select <= 1'b0;
      low_pend    <= 1'b0;
      init_step   <= 4'd0;
      pins        <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      held_byte   <= held_byte_next;
      held_select <= held_select_next;
      low_pend    <= low_pend_next;
      init_step   <= init_step_next;
      pins        <= pins_next;
    end
  end

  // Pin levels after this tick
  assign result.accepted   = acc;
  assign result.busy       = (phase_next != lcd4w_pkg::PH_IDLE);
  assign result.nibble     = pins_next[3:0];
  assign result.enable     = pins_next[4];
  assign result.read_write = 1'b0;
  assign result.sel        = pins_next[5];

endmodule

`default_nettype wire
